/* rtl/alat_pkg.sv */
// ----------------------------------------------------------------------------
// alat_pkg: shared types, codes and helpers of the advanced load address table
// Operation codes, size handling, tag forming and the controller command.
// ----------------------------------------------------------------------------
`default_nettype none

package alat_pkg;

  localparam int unsigned ALAT_ENTRIES = 32;

  localparam int unsigned FUNC_W = 3;
  localparam int unsigned REG_W  = 15;
  localparam int unsigned TAG_W  = 16;
  localparam int unsigned ADDR_W = 64;
  localparam int unsigned SIZE_W = 3;
  localparam int unsigned MASK_W = 4;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADV_LOAD   = 3'd0,
    FUNC_CHK_LOAD   = 3'd1,
    FUNC_ADV_CHECK  = 3'd2,
    FUNC_STORE      = 3'd3,
    FUNC_REMOVE_REG = 3'd4,
    FUNC_INV_ALL    = 3'd5
  } func_e;

  typedef enum logic [SIZE_W-1:0] {
    SIZE_1B  = 3'd0,
    SIZE_2B  = 3'd1,
    SIZE_4B  = 3'd2,
    SIZE_8B  = 3'd3,
    SIZE_10B = 3'd4,
    SIZE_16B = 3'd5
  } size_e;

  typedef struct packed {
    logic capture;
    logic commit;
  } alat_cmd_t;

  // codes above the 16 byte code count as 16 bytes
  function automatic logic [SIZE_W-1:0] size_clamp(logic [SIZE_W-1:0] code);
    logic [SIZE_W-1:0] res;
    res = (code > SIZE_16B) ? SIZE_16B : code;
    return res;
  endfunction

  // low address bits ignored for an access of the given size
  function automatic logic [MASK_W-1:0] size_mask(logic [SIZE_W-1:0] code);
    logic [MASK_W-1:0] res;
    unique case (code)
      SIZE_1B: res = 4'h0;
      SIZE_2B: res = 4'h1;
      SIZE_4B: res = 4'h3;
      SIZE_8B: res = 4'h7;
      default: res = 4'hf;
    endcase
    return res;
  endfunction

  // float register n shares its tag with general register 2n
  function automatic logic [TAG_W-1:0] make_tag(logic is_float, logic [REG_W-1:0] num);
    logic [TAG_W-1:0] res;
    res = is_float ? {num, 1'b0} : {1'b0, num};
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/alat_in_if.sv */
// ----------------------------------------------------------------------------
// alat_in_if: request channel of the advanced load address table
// Valid/ready handshake with one operation per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface alat_in_if;
  logic                          valid;
  logic                          ready;
  logic [alat_pkg::FUNC_W-1:0]   func;
  logic                          reg_is_float;
  logic [alat_pkg::REG_W-1:0]    reg_num;
  logic [alat_pkg::ADDR_W-1:0]   address;
  logic [alat_pkg::SIZE_W-1:0]   size_code;
  logic                          clear_flag;

  modport source (
    output valid, func, reg_is_float, reg_num, address, size_code, clear_flag,
    input  ready
  );
  modport sink (
    input  valid, func, reg_is_float, reg_num, address, size_code, clear_flag,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/alat_out_if.sv */
// ----------------------------------------------------------------------------
// alat_out_if: result channel of the advanced load address table
// Valid/ready handshake with one result per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface alat_out_if;
  logic valid;
  logic ready;
  logic hit;
  logic table_full;

  modport source (
    output valid, hit, table_full,
    input  ready
  );
  modport sink (
    input  valid, hit, table_full,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/alat_ctrl.sv */
// ----------------------------------------------------------------------------
// alat_ctrl: sequencing of the advanced load address table
// Takes a request beat, commits it once the result register is free and owns the result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module alat_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      alat_pkg::alat_cmd_t cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free      = !out_valid_q || out_ready_i;
  assign in_ready_o    = (state_q == ST_IDLE);
  assign cmd_o.capture = in_valid_i && (state_q == ST_IDLE);
  assign cmd_o.commit  = (state_q == ST_UPDATE) && out_free;
  assign out_valid_o   = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_UPDATE;
          end
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
          end
        end
        ST_UPDATE: begin
          // hold the update until the result register can take it
          if (out_free) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/alat_dpath.sv */
// ----------------------------------------------------------------------------
// alat_dpath: entry storage, match logic and update of the table
// Per-entry tag and store compares on capture, valid update on commit.
// ----------------------------------------------------------------------------
`default_nettype none

module alat_dpath #(
  parameter int unsigned ENTRIES = alat_pkg::ALAT_ENTRIES
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire alat_pkg::alat_cmd_t         cmd_i,
  input  wire logic [alat_pkg::FUNC_W-1:0] func_i,
  input  wire logic                        reg_is_float_i,
  input  wire logic [alat_pkg::REG_W-1:0]  reg_num_i,
  input  wire logic [alat_pkg::ADDR_W-1:0] address_i,
  input  wire logic [alat_pkg::SIZE_W-1:0] size_code_i,
  input  wire logic                        clear_flag_i,
  output      logic                        hit_o,
  output      logic                        table_full_o
);

  localparam int unsigned TW = alat_pkg::TAG_W;
  localparam int unsigned AW = alat_pkg::ADDR_W;
  localparam int unsigned SW = alat_pkg::SIZE_W;
  localparam int unsigned MW = alat_pkg::MASK_W;

  // captured request
  alat_pkg::func_e        func_q;
  logic [TW-1:0]          tag_q;
  logic [AW-1:0]          addr_q;
  logic [SW-1:0]          size_q;
  logic                   clr_q;
  logic [ENTRIES-1:0]     tag_match_q;
  logic [ENTRIES-1:0]     st_match_q;

  // entries
  logic [ENTRIES-1:0]     valid_q;
  logic [TW-1:0]          slot_tag_q  [ENTRIES];
  logic [AW-1:0]          slot_addr_q [ENTRIES];
  logic [SW-1:0]          slot_size_q [ENTRIES];

  logic                   hit_q;
  logic                   full_q;

  logic [TW-1:0]          tag_d;
  logic [SW-1:0]          size_d;
  logic [ENTRIES-1:0]     tag_match_d;
  logic [ENTRIES-1:0]     st_match_d;

  logic                   tag_hit;
  logic                   hit_d;
  logic                   ins;
  logic [ENTRIES-1:0]     drop;
  logic [ENTRIES-1:0]     valid_kept;
  logic [ENTRIES-1:0]     pick;
  logic [ENTRIES-1:0]     valid_d;

  assign tag_d  = alat_pkg::make_tag(reg_is_float_i, reg_num_i);
  assign size_d = alat_pkg::size_clamp(size_code_i);

  // compares run against the incoming beat; the entries cannot change
  // before its commit
  always_comb begin
    logic [SW-1:0] big;
    logic [MW-1:0] m;
    tag_match_d = '0;
    st_match_d  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      big = (slot_size_q[i] < size_d) ? size_d : slot_size_q[i];
      m   = alat_pkg::size_mask(big);
      tag_match_d[i] = (slot_tag_q[i] == tag_d);
      st_match_d[i]  = (address_i[AW-1:MW] == slot_addr_q[i][AW-1:MW]) &&
                       ((address_i[MW-1:0] & ~m) == (slot_addr_q[i][MW-1:0] & ~m));
    end
  end

  assign tag_hit = |(tag_match_q & valid_q);

  always_comb begin
    drop  = '0;
    ins   = 1'b0;
    hit_d = 1'b0;
    unique case (func_q)
      alat_pkg::FUNC_ADV_LOAD: begin
        drop = tag_match_q;
        ins  = 1'b1;
      end
      alat_pkg::FUNC_CHK_LOAD: begin
        hit_d = tag_hit;
        drop  = clr_q ? tag_match_q : '0;
        ins   = !clr_q && !tag_hit;
      end
      alat_pkg::FUNC_ADV_CHECK: begin
        hit_d = tag_hit;
        drop  = (tag_hit && clr_q) ? tag_match_q : '0;
      end
      alat_pkg::FUNC_STORE:      drop = st_match_q;
      alat_pkg::FUNC_REMOVE_REG: drop = tag_match_q;
      alat_pkg::FUNC_INV_ALL:    drop = '1;
      default: begin
        drop = '0;
      end
    endcase
  end

  // lowest free slot: isolate the lowest zero of the kept valid bits
  assign valid_kept = valid_q & ~drop;
  assign pick       = ~valid_kept & (valid_kept + ENTRIES'(1));
  assign valid_d    = ins ? (valid_kept | pick) : valid_kept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.commit) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q      <= alat_pkg::func_e'(func_i);
      tag_q       <= tag_d;
      addr_q      <= address_i;
      size_q      <= size_d;
      clr_q       <= clear_flag_i;
      tag_match_q <= tag_match_d;
      st_match_q  <= st_match_d;
    end
    if (cmd_i.commit) begin
      hit_q  <= hit_d;
      full_q <= &valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ENTRIES; i++) begin
      if (cmd_i.commit && ins && pick[i]) begin
        slot_tag_q[i]  <= tag_q;
        slot_addr_q[i] <= addr_q;
        slot_size_q[i] <= size_q;
      end
    end
  end

  assign hit_o        = hit_q;
  assign table_full_o = full_q;

endmodule

`default_nettype wire

/* rtl/advanced_load_address_table.sv */
// ----------------------------------------------------------------------------
// advanced_load_address_table: fully associative table of speculative loads
// Tracks advanced loads by register tag and address, checks and clears them.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one operation per beat (advanced load, check load, advanced
//   check, store update, remove register, invalidate all). out_o returns one
//   beat per operation with the hit flag and whether every slot is in use.
//   A beat is accepted and compared against all slots in parallel; then
//   the update state writes the valid bits and, for an inserting operation,
//   the lowest free slot once the result register is free. The result is
//   valid from that update edge on. One operation is in flight at a time,
//   so no new beat is taken before the pending one is committed; in_i.ready
//   is high while no operation is pending.
//   The result register lets the next beat be accepted while a result waits.
//   If out_o stalls, the pending update waits for the result register and
//   in_i holds ready low meanwhile.
//   Reset clears all valid bits; the table is empty at once, no sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module advanced_load_address_table #(
  parameter int unsigned ENTRIES = alat_pkg::ALAT_ENTRIES
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  alat_in_if.sink     in_i,
  alat_out_if.source  out_o
);

  alat_pkg::alat_cmd_t cmd;

  alat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  alat_dpath #(
    .ENTRIES (ENTRIES)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .func_i         (in_i.func),
    .reg_is_float_i (in_i.reg_is_float),
    .reg_num_i      (in_i.reg_num),
    .address_i      (in_i.address),
    .size_code_i    (in_i.size_code),
    .clear_flag_i   (in_i.clear_flag),
    .hit_o          (out_o.hit),
    .table_full_o   (out_o.table_full)
  );

endmodule

`default_nettype wire

/* rtl/alat_checker.sv */
// ----------------------------------------------------------------------------
// alat_checker: port level checks of the advanced load address table
// Sequencing of beats and results, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module alat_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_i,
  input wire logic [alat_pkg::FUNC_W-1:0] in_func_i,
  input wire logic                        out_valid_i,
  input wire logic                        out_ready_i,
  input wire logic                        out_hit_i,
  input wire logic                        out_full_i
);

  logic in_acc;
  logic out_free;

  assign in_acc   = in_valid_i && in_ready_i;
  assign out_free = !out_valid_i || out_ready_i;

  // a result waiting for the receiver holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_hit_i) && $stable(out_full_i))
    else $error("result beat changed while stalled");

  // one operation in flight: no beat taken right after another
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("request accepted while an operation is pending");

  // with room at the output, the update of a beat is not held back by the result register
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && out_free |-> ##2 out_valid_i)
    else $error("result missing two cycles after request");

  // invalidate all leaves a table that is not full and reports no hit
  a_inv_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && out_free && (in_func_i == alat_pkg::FUNC_INV_ALL)
      |-> ##2 (!out_full_i && !out_hit_i))
    else $error("table reported full or hit after invalidate all");

endmodule

bind advanced_load_address_table alat_checker u_alat_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_func_i   (in_i.func),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_hit_i   (out_o.hit),
  .out_full_i  (out_o.table_full)
);

`default_nettype wire
